// File: rtl/settable_mmss_clock_display_assert.svh
// Assertion macros shared by the clock display RTL.
`ifndef SETTABLE_MMSS_CLOCK_DISPLAY_ASSERT_SVH
`define SETTABLE_MMSS_CLOCK_DISPLAY_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property with the asynchronous reset disabling the check.
`define SMMSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds while reset is asserted.
`define SMMSS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SMMSS_ASSERT(label, clk, rst_n, prop, msg)
`define SMMSS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/smmss_pkg.sv
// Types, constants and decode functions of the MM:SS clock display.
package smmss_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int DIGIT_W    = 5;
	localparam int POS_W      = 2;

	localparam logic [DIGIT_W-1:0] BLANK_CODE = 5'd16;

	localparam logic [3:0] KEY_LEFT  = 4'd10;
	localparam logic [3:0] KEY_RIGHT = 4'd11;
	localparam logic [3:0] KEY_EXIT  = 4'd14;
	localparam logic [3:0] KEY_SET   = 4'd15;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	localparam logic CFG_TICKS_PER_SECOND  = 1'b0;
	localparam logic CFG_BLINK_HALF_PERIOD = 1'b1;

	localparam logic [15:0] TPS_RESET = 16'd500;
	localparam logic [14:0] BHP_RESET = 15'd250;

	typedef struct packed {
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
		logic [POS_W-1:0]                   scan_pos;
		logic [POS_W-1:0]                   scan_lim;
		logic                               set_mode;
		logic [POS_W-1:0]                   cursor;
		logic [DIGIT_W-1:0]                 saved;
		logic [15:0]                        blink;
		logic [15:0]                        ticks;
		logic [3:0]                         enable;
		logic [7:0]                         segments;
	} smmss_state_t;

	// Active-low segments a..g; codes above blank show nothing.
	function automatic logic [7:0] segment_code(input logic [DIGIT_W-1:0] code);
		logic [7:0] seg;
		unique case (code)
			5'd0:    seg = 8'hc0;
			5'd1:    seg = 8'hf9;
			5'd2:    seg = 8'ha4;
			5'd3:    seg = 8'hb0;
			5'd4:    seg = 8'h99;
			5'd5:    seg = 8'h92;
			5'd6:    seg = 8'h82;
			5'd7:    seg = 8'hf8;
			5'd8:    seg = 8'h80;
			5'd9:    seg = 8'h90;
			5'd10:   seg = 8'h88;
			5'd11:   seg = 8'h83;
			5'd12:   seg = 8'hc6;
			5'd13:   seg = 8'ha1;
			5'd14:   seg = 8'h86;
			5'd15:   seg = 8'h8e;
			default: seg = 8'hff;
		endcase
		return seg;
	endfunction

	function automatic logic [3:0] enable_code(input logic [POS_W-1:0] pos);
		logic [3:0] en;
		unique case (pos)
			2'd0:    en = 4'he;
			2'd1:    en = 4'hd;
			2'd2:    en = 4'hb;
			default: en = 4'h7;
		endcase
		return en;
	endfunction

	// Seconds and minutes ones count to ten, tens digits to six.
	function automatic logic [5:0] digit_modulus(input logic [POS_W-1:0] pos);
		return pos[0] ? 6'd6 : 6'd10;
	endfunction

endpackage

// File: rtl/smmss_if.sv
// Valid/ready channel interfaces of the MM:SS clock display.
interface smmss_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [3:0] key_code;

	modport source (output valid, output command, output key_code, input ready);
	modport sink (input valid, input command, input key_code, output ready);
endinterface

interface smmss_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_enable;
	logic [7:0] segment_pattern;
	logic       setting_mode;
	logic [1:0] cursor_digit;

	modport source (output valid, output digit_enable, output segment_pattern,
		output setting_mode, output cursor_digit, input ready);
	modport sink (input valid, input digit_enable, input segment_pattern,
		input setting_mode, input cursor_digit, output ready);
endinterface

interface smmss_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/smmss_step.sv
// Next-state logic for one tick or key request of the clock display.
module smmss_step
	import smmss_pkg::*;
(
	input  smmss_state_t st,
	input  logic         command,
	input  logic [3:0]   key_code,
	input  logic [15:0]  ticks_per_second,
	input  logic [14:0]  blink_half_period,
	output smmss_state_t nx
);

	always_comb begin
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   lim;
		logic [POS_W-1:0]   cur;
		logic [POS_W:0]     nxt;
		logic               skip;
		logic [7:0]         seg;
		logic [DIGIT_W-1:0] dc;
		logic [DIGIT_W-1:0] sv;
		logic [DIGIT_W-1:0] k;
		logic [15:0]        bc;
		logic [15:0]        tc;
		logic [5:0]         v;
		logic               carry;

		nx    = st;
		pos   = st.scan_pos;
		lim   = st.scan_lim;
		cur   = st.cursor;
		nxt   = '0;
		skip  = 1'b0;
		seg   = '0;
		dc    = '0;
		sv    = '0;
		k     = {1'b0, key_code};
		bc    = '0;
		tc    = '0;
		v     = '0;
		carry = 1'b0;

		if (command == CMD_TICK) begin
			// Drive the current scan digit from the digits as they stand.
			seg = segment_code(st.digits[pos]);
			if (pos == 2'd2)
				seg[7] = 1'b0;
			nx.enable   = enable_code(pos);
			nx.segments = seg;

			if (st.set_mode) begin
				lim = 2'd3;
			end else begin
				if (st.digits[0] != '0) lim = 2'd0;
				if (st.digits[1] != '0) lim = 2'd1;
				if (st.digits[2] != '0) lim = 2'd2;
				if (st.digits[3] != '0) lim = 2'd3;
				// Single-digit minutes with zero seconds tens skips digit one.
				if (st.digits[3] == '0 && st.digits[2] != '0 && st.digits[1] == '0) begin
					lim  = 2'd2;
					skip = 1'b1;
				end
			end
			nxt = {1'b0, pos} + {2'b00, skip} + 3'd1;
			nx.scan_lim = lim;
			nx.scan_pos = (nxt > {1'b0, lim}) ? '0 : nxt[POS_W-1:0];

			if (st.set_mode) begin
				dc = st.digits[st.cursor];
				sv = (dc != BLANK_CODE) ? dc : st.saved;
				nx.saved = sv;
				bc = st.blink + 16'd1;
				if (bc < {1'b0, blink_half_period}) begin
					nx.digits[st.cursor] = BLANK_CODE;
					nx.blink = bc;
				end else if (bc < {blink_half_period, 1'b0}) begin
					nx.digits[st.cursor] = sv;
					nx.blink = bc;
				end else begin
					nx.blink = '0;
				end
			end else begin
				tc = st.ticks + 16'd1;
				if (tc == ticks_per_second) begin
					nx.ticks = '0;
					carry = 1'b1;
					for (int i = 0; i < NUM_DIGITS; i++) begin
						if (carry) begin
							v = {1'b0, st.digits[i]} + 6'd1;
							if (v >= digit_modulus(POS_W'(i))) begin
								nx.digits[i] = '0;
							end else begin
								nx.digits[i] = v[DIGIT_W-1:0];
								carry = 1'b0;
							end
						end
					end
				end else begin
					nx.ticks = tc;
				end
			end
		end else if (st.set_mode || key_code == KEY_SET) begin
			nx.set_mode = 1'b1;
			if (key_code == KEY_RIGHT) begin
				nx.digits[cur] = st.saved;
				cur = cur + 2'd1;
				k = BLANK_CODE;
			end
			if (key_code == KEY_LEFT) begin
				nx.digits[cur] = st.saved;
				cur = cur - 2'd1;
				k = BLANK_CODE;
			end
			if (k < (cur[0] ? 5'd6 : 5'd10)) begin
				nx.digits[cur] = k;
				cur = cur - 2'd1;
				k = BLANK_CODE;
			end
			if (k == {1'b0, KEY_EXIT}) begin
				nx.set_mode = 1'b0;
				nx.digits[cur] = st.saved;
				cur = 2'd3;
			end
			nx.cursor = cur;
		end
	end

endmodule

// File: rtl/settable_mmss_clock_display.sv
// A request is held in the s1 registers, then its update is registered into state_q.
// One request per cycle unless results stall; each state update is a registered pass.
// The display state doubles as the result register, so a stalled result holds it.
// Configuration writes are taken every cycle; ready is always high on that port.
// Reset clears the digits to zero, the cursor to three and all digits off,
// with 500 ticks per second and a blink half period of 250 ticks.
`include "settable_mmss_clock_display_assert.svh"

module settable_mmss_clock_display
	import smmss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	smmss_in_if.sink           item,
	smmss_out_if.source        result,
	smmss_cfg_if.sink          cfg
);

	logic         valid_s1;
	logic         command_s1;
	logic [3:0]   key_code_s1;
	logic         out_valid_q;
	logic [15:0]  tps_q;
	logic [14:0]  bhp_q;
	smmss_state_t state_q;
	smmss_state_t state_next;
	logic         advance;

	// The state only moves when the previous result has left.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			bhp_q <= BHP_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_TICKS_PER_SECOND)
				tps_q <= cfg.data;
			else
				bhp_q <= cfg.data[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1  <= item.command;
			key_code_s1 <= item.key_code;
		end
	end

	smmss_step u_step (
		.st                (state_q),
		.command           (command_s1),
		.key_code          (key_code_s1),
		.ticks_per_second  (tps_q),
		.blink_half_period (bhp_q),
		.nx                (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q       <= 1'b0;
			state_q.digits    <= '0;
			state_q.scan_pos  <= '0;
			state_q.scan_lim  <= '0;
			state_q.set_mode  <= 1'b0;
			state_q.cursor    <= 2'd3;
			state_q.saved     <= '0;
			state_q.blink     <= '0;
			state_q.ticks     <= '0;
			state_q.enable    <= 4'hf;
			state_q.segments  <= '0;
		end else begin
			if (advance)
				state_q <= state_next;
			if (advance)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.digit_enable    = state_q.enable;
	assign result.segment_pattern = state_q.segments;
	assign result.setting_mode    = state_q.set_mode;
	assign result.cursor_digit    = state_q.cursor;

	`SMMSS_ASSERT(a_cursor_rests, clk, arst_n, !state_q.set_mode |-> state_q.cursor == 2'd3, "cursor left off digit three outside set mode")
	`SMMSS_ASSERT(a_one_digit_on, clk, arst_n, $countones(state_q.enable) >= 3, "more than one digit enabled")
	`SMMSS_ASSERT(a_scan_in_limit, clk, arst_n, state_q.scan_pos <= state_q.scan_lim, "scan position beyond scan limit")
	`SMMSS_ASSERT(a_key_holds_segs, clk, arst_n, (advance && command_s1 == CMD_KEY) |=> $stable(state_q.segments), "key request changed the segments")
	`SMMSS_ASSERT(a_set_full_scan, clk, arst_n, (advance && command_s1 == CMD_TICK && state_q.set_mode) |=> state_q.scan_lim == 2'd3, "set mode tick did not open the full scan")

endmodule
